// ----- src/assert_macros.svh -----
// Assertion macros used by the spline evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hse_pkg.sv -----
// Types and constants of the Hermite spline evaluator.
package hse_pkg;

  localparam int FractionBits = 16;
  localparam int TimeW        = 21;
  localparam int SegFieldW    = 5;
  localparam int DataW        = 32;
  localparam int UW           = FractionBits + 1;
  localparam int BasisW       = UW + 4;
  localparam int ProdW        = DataW + BasisW;
  localparam int SumW         = ProdW + 3;

  localparam logic [SegFieldW-1:0] SegReset = SegFieldW'(16);
  localparam logic [UW-1:0]        OneU     = UW'(2 ** FractionBits);

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncEval  = 1'b1
  } hse_func_e;

  typedef logic [UW-1:0]            ufrac_t;
  typedef logic signed [BasisW-1:0] basis_t;
  typedef logic signed [DataW-1:0]  data_t;

  typedef struct packed {
    basis_t h00;
    basis_t h10;
    basis_t h01;
    basis_t h11;
    basis_t d00;
    basis_t d10;
    basis_t d01;
    basis_t d11;
  } hse_basis_t;

  typedef struct packed {
    data_t p0;
    data_t v0;
    data_t p1;
    data_t v1;
  } hse_points_t;

  typedef struct packed {
    logic ld_read;
    logic ld_sq;
    logic ld_cube;
    logic ld_basis;
    logic ld_prod;
    logic ld_out;
  } hse_ctl_t;

endpackage

// ----- src/hse_point_store.sv -----
// Control point memory with per-entry valid bits and two registered read ports.
module hse_point_store import hse_pkg::*; #(
  parameter int Depth = 17,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  data_t            wr_pos_i,
  input  data_t            wr_tan_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr0_i,
  input  logic [AddrW-1:0] rd_addr1_i,
  output hse_points_t      points_o
);

  data_t            pos_mem [Depth];
  data_t            tan_mem [Depth];
  logic [Depth-1:0] valid_q;
  hse_points_t      rd_q;
  logic             ok0_q;
  logic             ok1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ok0_q   <= 1'b0;
      ok1_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        ok0_q <= valid_q[rd_addr0_i];
        ok1_q <= valid_q[rd_addr1_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pos_mem[wr_addr_i] <= wr_pos_i;
      tan_mem[wr_addr_i] <= wr_tan_i;
    end
    if (rd_en_i) begin
      rd_q.p0 <= pos_mem[rd_addr0_i];
      rd_q.v0 <= tan_mem[rd_addr0_i];
      rd_q.p1 <= pos_mem[rd_addr1_i];
      rd_q.v1 <= tan_mem[rd_addr1_i];
    end
  end

  assign points_o.p0 = ok0_q ? rd_q.p0 : '0;
  assign points_o.v0 = ok0_q ? rd_q.v0 : '0;
  assign points_o.p1 = ok1_q ? rd_q.p1 : '0;
  assign points_o.v1 = ok1_q ? rd_q.v1 : '0;

endmodule

// ----- src/hse_basis.sv -----
// Pipeline stages for u squared, u cubed and the eight Hermite basis weights.
module hse_basis import hse_pkg::*; (
  input  logic       clk_i,
  input  hse_ctl_t   ctl_i,
  input  ufrac_t     u_i,
  output hse_basis_t basis_o
);

  localparam int RW = 2 * UW + 1;
  localparam logic [RW-1:0] HalfR = RW'(2 ** (FractionBits - 1));
  localparam basis_t K2   = basis_t'(2);
  localparam basis_t K3   = basis_t'(3);
  localparam basis_t K4   = basis_t'(4);
  localparam basis_t K6   = basis_t'(6);
  localparam basis_t OneB = basis_t'(OneU);

  ufrac_t     u1_q;
  ufrac_t     u2_q;
  ufrac_t     sq2_q;
  ufrac_t     u3_q;
  ufrac_t     sq3_q;
  ufrac_t     cu3_q;
  logic [RW-1:0] sq_w;
  logic [RW-1:0] cu_w;
  basis_t     su;
  basis_t     su2;
  basis_t     su3;
  hse_basis_t basis_d;
  hse_basis_t basis_q;

  assign sq_w = RW'(u1_q) * RW'(u1_q) + HalfR;
  assign cu_w = RW'(sq2_q) * RW'(u2_q) + HalfR;

  assign su  = $signed(BasisW'(u3_q));
  assign su2 = $signed(BasisW'(sq3_q));
  assign su3 = $signed(BasisW'(cu3_q));

  always_comb begin
    basis_d.h00 = K2 * su3 - K3 * su2 + OneB;
    basis_d.h10 = su3 - K2 * su2 + su;
    basis_d.h01 = K3 * su2 - K2 * su3;
    basis_d.h11 = su3 - su2;
    basis_d.d00 = K6 * su2 - K6 * su;
    basis_d.d10 = K3 * su2 - K4 * su + OneB;
    basis_d.d01 = K6 * su - K6 * su2;
    basis_d.d11 = K3 * su2 - K2 * su;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_read) begin
      u1_q <= u_i;
    end
    if (ctl_i.ld_sq) begin
      u2_q  <= u1_q;
      sq2_q <= sq_w[FractionBits +: UW];
    end
    if (ctl_i.ld_cube) begin
      u3_q  <= u2_q;
      sq3_q <= sq2_q;
      cu3_q <= cu_w[FractionBits +: UW];
    end
    if (ctl_i.ld_basis) begin
      basis_q <= basis_d;
    end
  end

  assign basis_o = basis_q;

endmodule

// ----- src/hse_combine.sv -----
// Weighted sums of control points, rounding and saturation of the results.
module hse_combine import hse_pkg::*; (
  input  logic        clk_i,
  input  hse_ctl_t    ctl_i,
  input  hse_points_t points_i,
  input  hse_basis_t  basis_i,
  output data_t       position_o,
  output data_t       velocity_o,
  output logic        saturated_o
);

  localparam int QW = SumW - FractionBits;
  localparam logic signed [SumW-1:0] HalfS = SumW'(2 ** (FractionBits - 1));

  hse_points_t pts2_q;
  hse_points_t pts3_q;
  hse_points_t pts4_q;
  logic signed [ProdW-1:0] pp_q [8];
  logic signed [SumW-1:0]  pos_sum;
  logic signed [SumW-1:0]  vel_sum;
  logic [QW-1:0] pos_qv;
  logic [QW-1:0] vel_qv;
  logic          pos_ovf;
  logic          vel_ovf;
  data_t         pos_d;
  data_t         vel_d;
  data_t         pos_q;
  data_t         vel_q;
  logic          sat_q;

  always_comb begin
    pos_sum = SumW'(pp_q[0]) + SumW'(pp_q[1]) + SumW'(pp_q[2]) + SumW'(pp_q[3]) + HalfS;
    vel_sum = SumW'(pp_q[4]) + SumW'(pp_q[5]) + SumW'(pp_q[6]) + SumW'(pp_q[7]) + HalfS;
    pos_qv  = pos_sum[SumW-1:FractionBits];
    vel_qv  = vel_sum[SumW-1:FractionBits];
    pos_ovf = !((&pos_qv[QW-1:DataW-1]) || !(|pos_qv[QW-1:DataW-1]));
    vel_ovf = !((&vel_qv[QW-1:DataW-1]) || !(|vel_qv[QW-1:DataW-1]));
    pos_d   = pos_qv[DataW-1:0];
    vel_d   = vel_qv[DataW-1:0];
    if (pos_ovf) begin
      pos_d = pos_qv[QW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
    if (vel_ovf) begin
      vel_d = vel_qv[QW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sq) begin
      pts2_q <= points_i;
    end
    if (ctl_i.ld_cube) begin
      pts3_q <= pts2_q;
    end
    if (ctl_i.ld_basis) begin
      pts4_q <= pts3_q;
    end
    if (ctl_i.ld_prod) begin
      pp_q[0] <= basis_i.h00 * pts4_q.p0;
      pp_q[1] <= basis_i.h10 * pts4_q.v0;
      pp_q[2] <= basis_i.h01 * pts4_q.p1;
      pp_q[3] <= basis_i.h11 * pts4_q.v1;
      pp_q[4] <= basis_i.d00 * pts4_q.p0;
      pp_q[5] <= basis_i.d10 * pts4_q.v0;
      pp_q[6] <= basis_i.d01 * pts4_q.p1;
      pp_q[7] <= basis_i.d11 * pts4_q.v1;
    end
    if (ctl_i.ld_out) begin
      pos_q <= pos_d;
      vel_q <= vel_d;
      sat_q <= pos_ovf || vel_ovf;
    end
  end

  assign position_o  = pos_q;
  assign velocity_o  = vel_q;
  assign saturated_o = sat_q;

endmodule

// ----- src/hermite_spline_evaluator_core.sv -----
// Top level of the uniform cubic Hermite spline evaluator.
// Input channel: in_valid_i / in_stall_o with func_i and the point and time fields.
// A write request (func 0) stores one control point at once and returns nothing;
// an index above the segment count is dropped. An evaluate request (func 1)
// returns position, velocity and a saturation flag on out_valid_o / out_stall_i.
// Pipeline: the request loads the first of six register stages at acceptance
// (point read, square, cube, basis, products, sum and saturate); out_valid_o
// rises when the result reaches the last stage.
// Throughput: one request per cycle; each stage takes a new request whenever it
// is empty or moves its own on, so bubbles close up while the receiver stalls.
// A stalled result holds on the outputs; the input stalls only when all six
// stages are full.
// Reset clears all control points to zero, sets segments to 16 and empties the
// pipeline. cfg_wr_en_i writes the segment count from cfg_wr_data_i.
// A time at or past the last point evaluates the last segment at u = 1.
`include "assert_macros.svh"

module hermite_spline_evaluator_core import hse_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [SegFieldW-1:0] cfg_wr_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [SegFieldW-1:0] point_index_i,
  input  data_t                point_position_i,
  input  data_t                point_tangent_i,
  input  logic [TimeW-1:0]     sample_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output data_t                position_out_o,
  output data_t                velocity_out_o,
  output logic                 saturated_o
);

  localparam int MaxIdx = 2 ** SegFieldW - 1;
  localparam int Depth  = ((MAX_SEGMENTS < MaxIdx) ? MAX_SEGMENTS : MaxIdx) + 1;
  localparam int AddrW  = $clog2(Depth);

  logic [SegFieldW-1:0] segs_q;
  logic [SegFieldW-1:0] seg_eff;
  logic [SegFieldW-1:0] t_int;
  logic [SegFieldW-1:0] seg_sel;
  logic [SegFieldW-1:0] seg_nxt;
  ufrac_t               u0;
  logic [6:1]           v_q;
  logic [6:1]           en;
  logic                 accept;
  logic                 eval_req;
  logic                 wr_req;
  hse_ctl_t             ctl;
  hse_points_t          points;
  hse_basis_t           basis;

  always_comb begin
    priority if (segs_q == '0) begin
      seg_eff = SegFieldW'(1);
    end else if (int'(segs_q) > MAX_SEGMENTS) begin
      seg_eff = SegFieldW'(MAX_SEGMENTS);
    end else begin
      seg_eff = segs_q;
    end
  end

  assign t_int = sample_time_i[TimeW-1:FractionBits];

  always_comb begin
    if (t_int < seg_eff) begin
      seg_sel = t_int;
      u0      = {1'b0, sample_time_i[FractionBits-1:0]};
    end else begin
      seg_sel = seg_eff - SegFieldW'(1);
      u0      = OneU;
    end
  end

  assign seg_nxt = seg_sel + SegFieldW'(1);

  always_comb begin
    en[6] = !v_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign accept   = in_valid_i && en[1];
  assign eval_req = accept && (func_i == FuncEval);
  assign wr_req   = accept && (func_i == FuncWrite) && (point_index_i <= seg_eff);

  assign ctl.ld_read  = en[1];
  assign ctl.ld_sq    = en[2];
  assign ctl.ld_cube  = en[3];
  assign ctl.ld_basis = en[4];
  assign ctl.ld_prod  = en[5];
  assign ctl.ld_out   = en[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segs_q <= SegReset;
      v_q    <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        segs_q <= cfg_wr_data_i;
      end
      if (en[1]) begin
        v_q[1] <= eval_req;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  hse_point_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_req),
    .wr_addr_i  (point_index_i[AddrW-1:0]),
    .wr_pos_i   (point_position_i),
    .wr_tan_i   (point_tangent_i),
    .rd_en_i    (eval_req),
    .rd_addr0_i (seg_sel[AddrW-1:0]),
    .rd_addr1_i (seg_nxt[AddrW-1:0]),
    .points_o   (points)
  );

  hse_basis u_basis (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .u_i     (u0),
    .basis_o (basis)
  );

  hse_combine u_combine (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .points_i    (points),
    .basis_i     (basis),
    .position_o  (position_out_o),
    .velocity_o  (velocity_out_o),
    .saturated_o (saturated_o)
  );

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[6];

  `ASSERT_IMPL(a_stall_full, in_stall_o, (&v_q) && out_stall_i, "input stalled with room in pipe")
  `ASSERT_NEXT(a_write_no_result, in_valid_i && !in_stall_o && !func_i, !v_q[1], "write request entered pipe")
  `ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !v_q[5], !out_valid_o, "result repeated")

endmodule

// ----- bench/tb_hermite_spline_evaluator_core.sv -----
// Self-checking testbench for the Hermite spline evaluator core.
`timescale 1ns / 100ps

module tb_hermite_spline_evaluator_core import hse_pkg::*;;

  localparam int MaxSeg      = 16;
  localparam int ResetCycles = 6;
  localparam int DrainCycles = 10;
  localparam int QuietLimit  = 4000;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 210;
  localparam data_t DataMax  = 32'sh7FFF_FFFF;
  localparam data_t DataMin  = 32'sh8000_0000;

  typedef struct {
    data_t position;
    data_t velocity;
    logic  clipped;
  } spline_sample_t;

  class spline_scoreboard;
    logic [SegFieldW-1:0] seg_reg;
    data_t                positions [MaxSeg+1];
    data_t                tangents [MaxSeg+1];
    spline_sample_t       pending_samples [$];
    int                   errors;

    function new();
      seg_reg = SegReset;
      foreach (positions[k]) begin
        positions[k] = '0;
        tangents[k]  = '0;
      end
      errors = 0;
    endfunction

    function int active_segments();
      if (seg_reg < 1) return 1;
      if (seg_reg > MaxSeg) return MaxSeg;
      return int'(seg_reg);
    endfunction

    function void set_segments(logic [SegFieldW-1:0] value);
      seg_reg = value;
    endfunction

    function data_t round_clip(longint acc, inout logic clipped);
      longint q;
      q = (acc + (longint'(1) <<< (FractionBits - 1))) >>> FractionBits;
      if (q > longint'(DataMax)) begin
        clipped = 1'b1;
        return DataMax;
      end
      if (q < longint'(DataMin)) begin
        clipped = 1'b1;
        return DataMin;
      end
      return data_t'(q);
    endfunction

    function spline_sample_t interpolate(int seg, longint uu);
      longint one, half, sq, cu, p0, v0, p1, v1, pos_acc, vel_acc;
      spline_sample_t s;
      one  = longint'(1) <<< FractionBits;
      half = one >>> 1;
      sq   = (uu * uu + half) >>> FractionBits;
      cu   = (sq * uu + half) >>> FractionBits;
      p0   = longint'(positions[seg]);
      v0   = longint'(tangents[seg]);
      p1   = longint'(positions[seg+1]);
      v1   = longint'(tangents[seg+1]);
      pos_acc = (2 * cu - 3 * sq + one) * p0 + (cu - 2 * sq + uu) * v0
              + (-2 * cu + 3 * sq) * p1 + (cu - sq) * v1;
      vel_acc = (6 * sq - 6 * uu) * p0 + (3 * sq - 4 * uu + one) * v0
              + (-6 * sq + 6 * uu) * p1 + (3 * sq - 2 * uu) * v1;
      s.clipped  = 1'b0;
      s.position = round_clip(pos_acc, s.clipped);
      s.velocity = round_clip(vel_acc, s.clipped);
      return s;
    endfunction

    function void note_request(hse_func_e func, logic [SegFieldW-1:0] idx, data_t pos,
                               data_t tan, logic [TimeW-1:0] t_fix);
      int     segs;
      int     seg;
      longint uu;
      segs = active_segments();
      if (func == FuncWrite) begin
        if (int'(idx) <= segs) begin
          positions[idx] = pos;
          tangents[idx]  = tan;
        end
        return;
      end
      seg = int'(t_fix >> FractionBits);
      uu  = longint'(t_fix[FractionBits-1:0]);
      if (seg >= segs) begin
        seg = segs - 1;
        uu  = longint'(1) <<< FractionBits;
      end
      pending_samples.push_back(interpolate(seg, uu));
    endfunction

    function void check_sample(data_t pos, data_t vel, logic clipped);
      spline_sample_t want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result position %0d velocity %0d saturated %0b",
                 $time, pos, vel, clipped);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (pos !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position, pos);
        errors++;
      end
      if (vel !== want.velocity) begin
        $display("%0t: velocity expected %0d actual %0d", $time, want.velocity, vel);
        errors++;
      end
      if (clipped !== want.clipped) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [SegFieldW-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  hse_func_e            func = FuncWrite;
  logic [SegFieldW-1:0] point_index = '0;
  data_t                point_position = '0;
  data_t                point_tangent = '0;
  logic [TimeW-1:0]     sample_time = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  data_t                position_out;
  data_t                velocity_out;
  logic                 saturated;

  spline_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int seg_plan [PhaseCount] = '{1, 0, 31, 16, 7, 17, 0, 3};
  int send_idle_plan [4] = '{0, 62, 0, 24};
  int stall_plan [4] = '{0, 0, 62, 24};

  hermite_spline_evaluator_core #(
    .MAX_SEGMENTS(MaxSeg)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .point_index_i   (point_index),
    .point_position_i(point_position),
    .point_tangent_i (point_tangent),
    .sample_time_i   (sample_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .position_out_o  (position_out),
    .velocity_out_o  (velocity_out),
    .saturated_o     (saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_sample(position_out, velocity_out, saturated);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic data_t pick_word();
    case ($urandom_range(0, 7))
      0, 1, 2: return data_t'($urandom);
      3:       return data_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      4:       return DataMax;
      5:       return DataMin;
      6:       return '0;
      default: return data_t'((int'($urandom_range(0, 16)) - 8) <<< FractionBits);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_time(int segs);
    case ($urandom_range(0, 9))
      0:       return TimeW'($urandom);
      1:       return TimeW'((segs << FractionBits) + $urandom_range(0, 3 << FractionBits));
      2:       return TimeW'($urandom_range(0, segs) << FractionBits);
      default: return TimeW'($urandom_range(0, (segs << FractionBits) - 1));
    endcase
  endfunction

  task automatic send_request(hse_func_e f, logic [SegFieldW-1:0] idx, data_t pos, data_t tan,
                              logic [TimeW-1:0] t_fix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= f;
    point_index    <= idx;
    point_position <= pos;
    point_tangent  <= tan;
    sample_time    <= t_fix;
    do @(posedge clk); while (in_stall);
    board.note_request(f, idx, pos, tan, t_fix);
  endtask

  task automatic write_point(int idx, data_t pos, data_t tan);
    send_request(FuncWrite, SegFieldW'(idx), pos, tan, TimeW'($urandom));
  endtask

  task automatic eval_at(int t_fix);
    send_request(FuncEval, SegFieldW'($urandom), pick_word(), pick_word(), TimeW'(t_fix));
  endtask

  task automatic random_request();
    int segs;
    segs = board.active_segments();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 85) write_point($urandom_range(0, segs), pick_word(), pick_word());
      else write_point($urandom_range(0, 31), pick_word(), pick_word());
    end else begin
      send_request(FuncEval, SegFieldW'($urandom), pick_word(), pick_word(), pick_time(segs));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_segments(logic [SegFieldW-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_segments(value);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    eval_at(0);
    write_point(0, DataMax, DataMin);
    write_point(1, DataMin, DataMax);
    write_point(16, 32'sh0003_8000, -32'sh0001_4000);
    write_point(17, 32'sh0000_0001, 32'sh0000_0001);
    write_point(31, DataMax, DataMax);
    eval_at(0);
    eval_at(32'h0_FFFF);
    eval_at(32'h0_8000);
    eval_at(1);
    eval_at(16 << FractionBits);
    eval_at(2 ** TimeW - 1);
    eval_at((15 << FractionBits) | 32'hFFFF);
    write_point(2, DataMax, DataMax);
    write_point(3, DataMax, '0);
    eval_at((2 << FractionBits) | 32'h8000);
    write_point(4, DataMin, DataMin);
    write_point(5, DataMin, '0);
    eval_at((4 << FractionBits) | 32'h8000);
    write_point(6, DataMin, '0);
    write_point(7, DataMax, DataMax);
    eval_at((6 << FractionBits) | 32'h8000);
    eval_at(1 << FractionBits);
    eval_at(17 << FractionBits);
    write_point(16, -32'sh0002_0000, 32'sh0000_C000);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 6) set_segments(SegFieldW'($urandom_range(0, 31)));
      else set_segments(SegFieldW'(seg_plan[p]));
      send_idle_pct = send_idle_plan[p % 4];
      stall_pct     = stall_plan[p % 4];
      repeat (PhaseItems) random_request();
    end

    drain();
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
